[src/vsfe_pkg.sv]
`timescale 1ns / 1ps

package vsfe_pkg;

   // Longest response frame that is kept; further bytes only enter the CRC.
   localparam int MAX_FRAME = 8;
   // Width of the receive count, which must hold MAX_FRAME itself.
   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   // Width of an index into the receive store.
   localparam int IDX_W = $clog2(MAX_FRAME);
   // Shortest response frame: address, function, length byte and two CRC bytes.
   localparam int MIN_FRAME = 5;
   // Width used when comparing the count with the length byte plus overhead.
   localparam int LEN_W = 9;

   // Depth of the queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // CRC-16, reflected polynomial, all-ones start value.
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [7:0] ADDR_RESET = 8'h01;

   // Input item kinds.
   localparam logic FUNC_REQUEST  = 1'b0;
   localparam logic FUNC_RESPONSE = 1'b1;

   // Result item kinds.
   localparam logic KIND_TX      = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Function codes with a known content rule.
   localparam logic [7:0] FC_READ_PARAM  = 8'h01;
   localparam logic [7:0] FC_WRITE_CTRL  = 8'h03;
   localparam logic [7:0] FC_READ_STATUS = 8'h04;
   localparam logic [7:0] FC_WRITE_FREQ  = 8'h05;

   // Verdict codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_LENGTH   = 3'd2;
   localparam logic [2:0] ST_ADDRESS  = 3'd3;
   localparam logic [2:0] ST_FUNCTION = 3'd4;
   localparam logic [2:0] ST_CRC      = 3'd5;
   localparam logic [2:0] ST_CONTENT  = 3'd6;

   // One classified item as it waits in the queue.
   typedef struct packed {
      logic            is_rx;
      logic [7:0]      function_code;
      logic [2:0]      len;
      logic [3:0][7:0] data;
      logic [7:0]      rx_byte;
      logic            rx_last;
   } vsfe_item_type;

   // Head of the queue as the back end sees it.
   typedef struct packed {
      logic          valid;
      vsfe_item_type item;
   } vsfe_head_type;

   // One byte through the CRC, all eight shifts unrolled.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data_in);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data_in};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[src/vsfe_front.sv]
`timescale 1ns / 1ps

module vsfe_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [7:0]             req_function_code,
   input  logic [2:0]             req_req_len,
   input  logic [7:0]             req_req_byte_0,
   input  logic [7:0]             req_req_byte_1,
   input  logic [7:0]             req_req_byte_2,
   input  logic [7:0]             req_req_byte_3,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_rx_last,
   input  logic                   queue_full,
   output logic                   push,
   output vsfe_pkg::vsfe_item_type push_item
);
   import vsfe_pkg::*;

   logic [2:0]      len_norm;
   logic [3:0][7:0] raw_data;

   // An item is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Clamp the request length into the range one to four.
   always_comb begin
      if (req_req_len == 3'd0) begin
         len_norm = 3'd1;
      end else if (req_req_len > 3'd4) begin
         len_norm = 3'd4;
      end else begin
         len_norm = req_req_len;
      end
   end

   assign raw_data = {req_req_byte_3, req_req_byte_2, req_req_byte_1, req_req_byte_0};

   // Classify the item and zero the data bytes that the request does not use.
   always_comb begin
      push_item.is_rx         = (req_func == FUNC_RESPONSE);
      push_item.function_code = req_function_code;
      push_item.len           = len_norm;
      for (int i = 0; i < 4; i++) begin
         push_item.data[i] = (3'(i) < len_norm) ? raw_data[i] : 8'h00;
      end
      push_item.rx_byte = req_rx_byte;
      push_item.rx_last = req_rx_last;
   end

endmodule

[src/vsfe_queue.sv]
`timescale 1ns / 1ps

module vsfe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  vsfe_pkg::vsfe_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output vsfe_pkg::vsfe_head_type head
);
   import vsfe_pkg::*;

   vsfe_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head.valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/vsfe_back.sv]
`timescale 1ns / 1ps

module vsfe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              slave_address,
   input  vsfe_pkg::vsfe_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_kind,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_last,
   output logic [2:0]              rsp_status,
   output logic [15:0]             rsp_value
);
   import vsfe_pkg::*;

   typedef enum logic {S_IDLE, S_SEND} state_type;

   state_type        state_ff, state_in;
   logic [2:0]       tx_idx_ff, tx_idx_in;
   logic [2:0]       tx_len_ff, tx_len_in;
   logic [15:0]      tx_crc_ff, tx_crc_in;
   logic [7:0]       sent_function_ff, sent_function_in;
   logic [3:0][7:0]  sent_data_ff, sent_data_in;
   logic [CNT_W-1:0] rx_count_ff, rx_count_in;
   logic             rx_over_ff, rx_over_in;
   logic [15:0]      rx_crc_ff, rx_crc_in;
   logic [7:0]       rx_store_ff [MAX_FRAME];
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_tx_byte_ff, rsp_tx_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [15:0]      rsp_value_ff, rsp_value_in;

   logic             out_free;
   logic             store_we;
   logic [7:0]       frame_byte;
   logic [3:0]       idx_wide;
   logic [3:0]       crc_lo_idx;
   logic [3:0]       end_idx;
   logic [7:0]       rx_b;
   logic [15:0]      crc_next;
   logic [CNT_W-1:0] count_next;
   logic             over_next;
   logic [7:0]       r [6];
   logic [2:0]       verdict;
   logic [15:0]      verdict_value;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Byte of the request frame at the current position.
   assign idx_wide   = {1'b0, tx_idx_ff};
   assign crc_lo_idx = {1'b0, tx_len_ff} + 4'd2;
   assign end_idx    = {1'b0, tx_len_ff} + 4'd3;

   always_comb begin
      if (tx_idx_ff == 3'd0) begin
         frame_byte = slave_address;
      end else if (tx_idx_ff == 3'd1) begin
         frame_byte = sent_function_ff;
      end else if (idx_wide < crc_lo_idx) begin
         frame_byte = sent_data_ff[2'(tx_idx_ff - 3'd2)];
      end else if (idx_wide == crc_lo_idx) begin
         frame_byte = tx_crc_ff[7:0];
      end else begin
         frame_byte = tx_crc_ff[15:8];
      end
   end

   // Receive path: running CRC, count and overflow including the byte at the head.
   assign rx_b       = head.item.rx_byte;
   assign crc_next   = crc_byte(rx_crc_ff, rx_b);
   assign store_we   = (rx_count_ff < CNT_W'(MAX_FRAME));
   assign count_next = store_we ? rx_count_ff + 1'b1 : rx_count_ff;
   assign over_next  = rx_over_ff || !store_we;

   // The first six frame bytes as they stand once the head byte is stored.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         r[k] = (rx_count_ff == CNT_W'(k)) ? rx_b : rx_store_ff[k];
      end
   end

   // Verdict on a complete response frame, in order of priority.
   always_comb begin
      verdict_value = 16'h0000;
      if (count_next < CNT_W'(MIN_FRAME)) begin
         verdict = ST_SHORT;
      end else if (over_next ||
                   (LEN_W'(count_next) != ({1'b0, r[2]} + LEN_W'(MIN_FRAME)))) begin
         verdict = ST_LENGTH;
      end else if (r[0] != slave_address) begin
         verdict = ST_ADDRESS;
      end else if (r[1] != sent_function_ff) begin
         verdict = ST_FUNCTION;
      end else if (crc_next != 16'h0000) begin
         verdict = ST_CRC;
      end else begin
         case (sent_function_ff)
            FC_READ_PARAM: begin
               if (r[3] != sent_data_ff[1] || (r[2] != 8'd2 && r[2] != 8'd3)) begin
                  verdict = ST_CONTENT;
               end else begin
                  verdict       = ST_OK;
                  verdict_value = (r[2] == 8'd2) ? {8'h00, r[4]} : {r[4], r[5]};
               end
            end
            FC_WRITE_CTRL: begin
               verdict = (r[2] == 8'd1 && r[3] == 8'd0) ? ST_OK : ST_CONTENT;
            end
            FC_READ_STATUS: begin
               if (r[2] != 8'd3 || r[3] != sent_data_ff[1]) begin
                  verdict = ST_CONTENT;
               end else begin
                  verdict       = ST_OK;
                  verdict_value = {r[4], r[5]};
               end
            end
            FC_WRITE_FREQ: begin
               verdict = (r[2] == 8'd2 && r[3] == sent_data_ff[1] &&
                          r[4] == sent_data_ff[2]) ? ST_OK : ST_CONTENT;
            end
            default: begin
               verdict = ST_CONTENT;
            end
         endcase
      end
   end

   // Sequencer: takes items from the queue and carries them out.
   always_comb begin
      state_in         = state_ff;
      tx_idx_in        = tx_idx_ff;
      tx_len_in        = tx_len_ff;
      tx_crc_in        = tx_crc_ff;
      sent_function_in = sent_function_ff;
      sent_data_in     = sent_data_ff;
      rx_count_in      = rx_count_ff;
      rx_over_in       = rx_over_ff;
      rx_crc_in        = rx_crc_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_kind_in      = rsp_kind_ff;
      rsp_tx_byte_in   = rsp_tx_byte_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_value_in     = rsp_value_ff;
      pop              = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               if (head.item.is_rx) begin
                  // A byte with no verdict needs no room at the output.
                  if (!head.item.rx_last || out_free) begin
                     pop         = 1'b1;
                     rx_count_in = count_next;
                     rx_over_in  = over_next;
                     rx_crc_in   = crc_next;
                     if (head.item.rx_last) begin
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = KIND_VERDICT;
                        rsp_tx_byte_in = 8'h00;
                        rsp_last_in    = 1'b1;
                        rsp_status_in  = verdict;
                        rsp_value_in   = (verdict == ST_OK) ? verdict_value : 16'h0000;
                        rx_count_in    = '0;
                        rx_over_in     = 1'b0;
                        rx_crc_in      = CRC_INIT;
                     end
                  end
               end else begin
                  // A new request drops any partly received response.
                  pop              = 1'b1;
                  sent_function_in = head.item.function_code;
                  sent_data_in     = head.item.data;
                  tx_len_in        = head.item.len;
                  tx_idx_in        = 3'd0;
                  tx_crc_in        = CRC_INIT;
                  rx_count_in      = '0;
                  rx_over_in       = 1'b0;
                  rx_crc_in        = CRC_INIT;
                  state_in         = S_SEND;
               end
            end
         end
         S_SEND: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_TX;
               rsp_tx_byte_in = frame_byte;
               rsp_last_in    = (idx_wide == end_idx);
               rsp_status_in  = ST_OK;
               rsp_value_in   = 16'h0000;
               if (idx_wide < crc_lo_idx) begin
                  tx_crc_in = crc_byte(tx_crc_ff, frame_byte);
               end
               tx_idx_in = tx_idx_ff + 3'd1;
               if (idx_wide == end_idx) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         tx_idx_ff        <= 3'd0;
         tx_len_ff        <= 3'd1;
         tx_crc_ff        <= CRC_INIT;
         sent_function_ff <= 8'h00;
         sent_data_ff     <= '0;
         rx_count_ff      <= '0;
         rx_over_ff       <= 1'b0;
         rx_crc_ff        <= CRC_INIT;
         rsp_valid_ff     <= 1'b0;
         rsp_kind_ff      <= KIND_TX;
         rsp_tx_byte_ff   <= 8'h00;
         rsp_last_ff      <= 1'b0;
         rsp_status_ff    <= ST_OK;
         rsp_value_ff     <= 16'h0000;
      end else begin
         state_ff         <= state_in;
         tx_idx_ff        <= tx_idx_in;
         tx_len_ff        <= tx_len_in;
         tx_crc_ff        <= tx_crc_in;
         sent_function_ff <= sent_function_in;
         sent_data_ff     <= sent_data_in;
         rx_count_ff      <= rx_count_in;
         rx_over_ff       <= rx_over_in;
         rx_crc_ff        <= rx_crc_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_kind_ff      <= rsp_kind_in;
         rsp_tx_byte_ff   <= rsp_tx_byte_in;
         rsp_last_ff      <= rsp_last_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_value_ff     <= rsp_value_in;
      end
   end

   // Receive store: written at the fill position, never cleared.
   always_ff @(posedge clock) begin
      if (pop && head.item.is_rx && store_we) begin
         rx_store_ff[rx_count_ff[IDX_W-1:0]] <= rx_b;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_tx_byte = rsp_tx_byte_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_value   = rsp_value_ff;

endmodule

[src/vfd_serial_frame_engine.sv]
`timescale 1ns / 1ps
// Channel    Ports                       Direction  Moves
// request    req_valid / req_stall       in         request item or one received byte
// response   rsp_valid / rsp_stall       out        transmit byte or response verdict
// config     csr_we / csr_wdata          in         slave address
//
// The back end takes received bytes while it is idle; a request frame of N data
// bytes goes out as N + 4 transmit bytes once the sequencer has loaded it.
// A four-entry queue lets the request side keep transferring while frames go out, until the queue is full.
// Reset is synchronous; afterwards the slave address is 1 and no response is pending.
// A stalled response register holds its byte; the back end waits on it only
// when it has a result to give.
module vfd_serial_frame_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_function_code,
   input  logic [2:0]  req_req_len,
   input  logic [7:0]  req_req_byte_0,
   input  logic [7:0]  req_req_byte_1,
   input  logic [7:0]  req_req_byte_2,
   input  logic [7:0]  req_req_byte_3,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_value,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   import vsfe_pkg::*;

   logic [7:0]    slave_address_ff;
   logic [7:0]    slave_address_in;
   logic          queue_full;
   logic          push;
   vsfe_item_type push_item;
   logic          pop;
   vsfe_head_type head;

   // Slave address register.
   assign slave_address_in = csr_we ? csr_wdata : slave_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= ADDR_RESET;
      end else begin
         slave_address_ff <= slave_address_in;
      end
   end

   vsfe_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_function_code (req_function_code),
      .req_req_len       (req_req_len),
      .req_req_byte_0    (req_req_byte_0),
      .req_req_byte_1    (req_req_byte_1),
      .req_req_byte_2    (req_req_byte_2),
      .req_req_byte_3    (req_req_byte_3),
      .req_rx_byte       (req_rx_byte),
      .req_rx_last       (req_rx_last),
      .queue_full        (queue_full),
      .push              (push),
      .push_item         (push_item)
   );

   vsfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   vsfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .slave_address (slave_address_ff),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .rsp_value     (rsp_value)
   );

   // A verdict is always the last item of its group and carries no byte.
   a_verdict_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_VERDICT) |-> (rsp_last && rsp_tx_byte == 8'h00))
      else $error("verdict without last flag or with a byte");

   // Only an ok verdict carries a value.
   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_value == 16'h0000))
      else $error("value given with a failing verdict");

   // Transmit bytes carry neither a status nor a value.
   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_TX) |-> (rsp_status == ST_OK && rsp_value == 16'h0000))
      else $error("transmit byte with status or value");

   // Output sits stable across a stall.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule
